// ----- hw/rtl/tag_header_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tag header decoder
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAG_HEADER_DECODER_UNIT_ASSERT_SVH
`define TAG_HEADER_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define THD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define THD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define THD_ASSERT_IMPL(name, ante, cons)
`define THD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hw/rtl/thd_pkg.sv -----
// ----------------------------------------------------------------------------
// thd_pkg
// Types and constants shared by the tag header decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package thd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int TAG_W   = 8;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 3;

    // Header decode constants
    localparam logic [3:0]         TAG_EXT_NIBBLE = 4'hF;
    localparam logic [2:0]         LVT_EXTENDED   = 3'd5;
    localparam logic [BYTE_W-1:0]  LEN_MARK_16    = 8'hFE;
    localparam logic [BYTE_W-1:0]  LEN_MARK_32    = 8'hFF;
    localparam logic [COUNT_W-1:0] LEN16_BYTES    = 3'd2;
    localparam logic [COUNT_W-1:0] LEN32_BYTES    = 3'd4;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAGNUM,
        PH_LENSEL,
        PH_LENDAT
    } phase_t;

    // Header decode state
    typedef struct packed {
        phase_t               phase;
        logic [TAG_W-1:0]     tag_number;
        logic                 class_bit;
        logic [LEN_W-1:0]     len_acc;
        logic [COUNT_W-1:0]   bytes_left;
        logic [COUNT_W-1:0]   byte_count;
    } state_t;

    // One decoded header
    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag_number;
        logic                 class_bit;
        logic [LEN_W-1:0]     length_value_type;
        logic [COUNT_W-1:0]   header_bytes;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/thd_decode.sv -----
// ----------------------------------------------------------------------------
// thd_decode
// Combinational step of the header decoder: next state and result for one
// byte applied to the current decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module thd_decode (
    input  wire  thd_pkg::state_t       st,
    input  wire  [thd_pkg::BYTE_W-1:0]  byte_in,
    input  wire                         start_req,
    output thd_pkg::state_t             st_next,
    output thd_pkg::result_t            res
);

    logic                           ext_tag;
    logic [thd_pkg::COUNT_W-1:0]    left_dec;
    logic [thd_pkg::COUNT_W-1:0]    count_inc;

    assign ext_tag   = byte_in[3] && (byte_in[7:4] == thd_pkg::TAG_EXT_NIBBLE);
    assign left_dec  = (st.bytes_left != '0) ? st.bytes_left - 3'd1 : '0;
    assign count_inc = st.byte_count + 3'd1;

    // Next state
    always_comb
    begin
        st_next = st;
        if (start_req)
        begin
            st_next.class_bit  = byte_in[3];
            st_next.tag_number = {4'b0000, byte_in[7:4]};
            st_next.len_acc    = {29'd0, byte_in[2:0]};
            st_next.byte_count = 3'd1;
            st_next.bytes_left = '0;
            if (ext_tag)
                st_next.phase = thd_pkg::PH_TAGNUM;
            else if (byte_in[2:0] == thd_pkg::LVT_EXTENDED)
                st_next.phase = thd_pkg::PH_LENSEL;
            else
                st_next.phase = thd_pkg::PH_IDLE;
        end
        else
        begin
            case (st.phase)
                thd_pkg::PH_TAGNUM:
                begin
                    st_next.tag_number = byte_in;
                    st_next.byte_count = count_inc;
                    if (st.len_acc == {29'd0, thd_pkg::LVT_EXTENDED})
                        st_next.phase = thd_pkg::PH_LENSEL;
                    else
                    begin
                        st_next.phase      = thd_pkg::PH_IDLE;
                        st_next.bytes_left = '0;
                    end
                end
                thd_pkg::PH_LENSEL:
                begin
                    st_next.byte_count = count_inc;
                    if (byte_in == thd_pkg::LEN_MARK_32)
                    begin
                        st_next.len_acc    = '0;
                        st_next.bytes_left = thd_pkg::LEN32_BYTES;
                        st_next.phase      = thd_pkg::PH_LENDAT;
                    end
                    else if (byte_in == thd_pkg::LEN_MARK_16)
                    begin
                        st_next.len_acc    = '0;
                        st_next.bytes_left = thd_pkg::LEN16_BYTES;
                        st_next.phase      = thd_pkg::PH_LENDAT;
                    end
                    else
                    begin
                        st_next.len_acc    = {24'd0, byte_in};
                        st_next.bytes_left = '0;
                        st_next.phase      = thd_pkg::PH_IDLE;
                    end
                end
                thd_pkg::PH_LENDAT:
                begin
                    st_next.len_acc    = {st.len_acc[23:0], byte_in};
                    st_next.byte_count = count_inc;
                    st_next.bytes_left = left_dec;
                    if (left_dec == '0)
                        st_next.phase = thd_pkg::PH_IDLE;
                end
                default:
                begin
                    // stray byte with no header open: ignored
                    st_next.phase = thd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result
    always_comb
    begin
        res.tag_number        = st_next.tag_number;
        res.class_bit         = st_next.class_bit;
        res.length_value_type = st_next.len_acc;
        res.header_bytes      = st_next.byte_count;
        if (start_req)
            res.valid = !ext_tag && (byte_in[2:0] != thd_pkg::LVT_EXTENDED);
        else
        begin
            case (st.phase)
                thd_pkg::PH_TAGNUM:
                    res.valid = (st.len_acc != {29'd0, thd_pkg::LVT_EXTENDED});
                thd_pkg::PH_LENSEL:
                    res.valid = (byte_in != thd_pkg::LEN_MARK_32)
                             && (byte_in != thd_pkg::LEN_MARK_16);
                thd_pkg::PH_LENDAT:
                    res.valid = (left_dec == '0);
                default:
                    res.valid = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tag_header_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tag_header_decoder_unit
// Decodes tag headers (tag number, class, length/value/type) from a byte
// stream, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one byte per item in s_tdata, s_tuser high on the
//   first byte of a header (it also drops any partial header). Bytes with
//   s_tuser low and no header open are ignored.
//   Output channel m_*: one item per completed header, giving tag number,
//   class, length/value/type and header size in bytes (1 to 7).
//   Path: the last header byte passes the input register, then the result
//   register, before its result is shown on m_tvalid.
//   Throughput: one byte per cycle while not stalled (see Stall); the
//   decode of each byte is a single pass through the next-state logic.
//   Stall: while a result waits on m_tready the input register can still
//   take one byte; s_tready drops only when that byte also needs to move
//   and the result register is still full.
//   Reset: rst_n clears both registers' valid flags and the decode state;
//   the block starts with no header open.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tag_header_decoder_unit_assert.svh"

module tag_header_decoder_unit (
    input  wire         clk,
    input  wire         rst_n,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] byte_in
    input  wire         s_tuser,    // [0] start_req
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata     // [7:0] tag_number, [8] class,
                                    // [40:9] length_value_type,
                                    // [43:41] header_bytes, [47:44] zero
);

    logic                          in_valid_reg;
    logic [thd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_start_reg;

    thd_pkg::state_t               state_reg;
    thd_pkg::state_t               state_next;
    thd_pkg::result_t              res;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    thd_pkg::result_t              out_reg;

    logic                          out_free;
    logic                          process;

    // Handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || process;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // Decode step
    thd_decode u_decode (
        .st        (state_reg),
        .byte_in   (in_byte_reg),
        .start_req (in_start_reg),
        .st_next   (state_next),
        .res       (res)
    );

    // Decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= thd_pkg::PH_IDLE;
            state_reg.tag_number <= '0;
            state_reg.class_bit  <= 1'b0;
            state_reg.len_acc    <= '0;
            state_reg.bytes_left <= '0;
            state_reg.byte_count <= '0;
        end
        else if (process)
            state_reg <= state_next;
    end

    // Result register
    always_comb
    begin
        if (process && res.valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (process && res.valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.header_bytes, out_reg.length_value_type,
                       out_reg.class_bit, out_reg.tag_number};

    // Checks
    `THD_ASSERT_IMPL(a_lendat_has_bytes, state_reg.phase == thd_pkg::PH_LENDAT,
                     state_reg.bytes_left != '0)
    `THD_ASSERT_IMPL(a_stall_only_when_full, !s_tready,
                     in_valid_reg && out_valid_reg && !m_tready)
    `THD_ASSERT_NEXT(a_result_lands, process && res.valid, m_tvalid)
    `THD_ASSERT_IMPL(a_size_nonzero, m_tvalid, out_reg.header_bytes != '0)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for tag_header_decoder_unit
// Streams tag header bytes into the decoder with random gaps on both sides.
// A scoreboard predicts each decoded header (tag number, class,
// length/value/type, header size) from the accepted bytes and compares
// every result item field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// One decoded header as the checker sees it
typedef struct packed {
    logic [7:0]  tag_num;
    logic        tag_cls;
    logic [31:0] lvt;
    logic [2:0]  hdr_size;
} header_t;

class header_scoreboard;
    localparam int MAX_PRINTED = 40;

    // shadow decode state
    thd_pkg::phase_t phase;
    logic [7:0]  tag_num;
    logic        tag_cls;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [2:0]  byte_cnt;

    header_t     pending_headers[$];
    int          errors;

    function new();
        phase    = thd_pkg::PH_IDLE;
        tag_num  = '0;
        tag_cls  = 1'b0;
        len_acc  = '0;
        len_left = '0;
        byte_cnt = '0;
        errors   = 0;
    endfunction

    // Advance the shadow decoder by one byte; returns 1 when a header completes
    function bit decode_byte(input logic [7:0] b, input logic start, output header_t hdr);
        bit tag_known;
        bit done;
        tag_known = 1'b0;
        done      = 1'b0;
        hdr       = '0;
        if (start)
        begin
            // first byte: nibble, class, short length field
            tag_cls  = b[3];
            tag_num  = {4'h0, b[7:4]};
            len_acc  = {29'd0, b[2:0]};
            byte_cnt = 3'd1;
            len_left = '0;
            if (b[3] && b[7:4] == thd_pkg::TAG_EXT_NIBBLE)
                phase = thd_pkg::PH_TAGNUM;
            else
                tag_known = 1'b1;
        end
        else
        begin
            case (phase)
                thd_pkg::PH_TAGNUM:
                begin
                    tag_num   = b;
                    byte_cnt  = byte_cnt + 3'd1;
                    tag_known = 1'b1;
                end
                thd_pkg::PH_LENSEL:
                begin
                    byte_cnt = byte_cnt + 3'd1;
                    if (b == thd_pkg::LEN_MARK_32)
                    begin
                        len_acc  = '0;
                        len_left = thd_pkg::LEN32_BYTES;
                        phase    = thd_pkg::PH_LENDAT;
                    end
                    else if (b == thd_pkg::LEN_MARK_16)
                    begin
                        len_acc  = '0;
                        len_left = thd_pkg::LEN16_BYTES;
                        phase    = thd_pkg::PH_LENDAT;
                    end
                    else
                    begin
                        len_acc = {24'd0, b};
                        done    = 1'b1;
                    end
                end
                thd_pkg::PH_LENDAT:
                begin
                    // big-endian length bytes
                    len_acc  = {len_acc[23:0], b};
                    byte_cnt = byte_cnt + 3'd1;
                    if (len_left != 0)
                        len_left = len_left - 3'd1;
                    done = (len_left == 0);
                end
                default:
                    phase = thd_pkg::PH_IDLE;
            endcase
        end

        // tag number settled: extended length or done
        if (tag_known)
        begin
            if (len_acc == {29'd0, thd_pkg::LVT_EXTENDED})
                phase = thd_pkg::PH_LENSEL;
            else
                done = 1'b1;
        end

        if (done)
        begin
            hdr.tag_num  = tag_num;
            hdr.tag_cls  = tag_cls;
            hdr.lvt      = len_acc;
            hdr.hdr_size = byte_cnt;
            phase        = thd_pkg::PH_IDLE;
            len_left     = '0;
        end
        return done;
    endfunction

    // Called for every accepted input item
    function void note_byte(logic [7:0] b, logic start);
        header_t hdr;
        if (decode_byte(b, start, hdr))
            pending_headers.push_back(hdr);
    endfunction

    task report_mismatch(string what);
        if (errors < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    // Called for every accepted result item
    task check_header(logic [47:0] data);
        header_t want;
        if (pending_headers.size() == 0)
        begin
            report_mismatch($sformatf("unexpected header item %h", data));
            return;
        end
        want = pending_headers.pop_front();
        if (data[7:0] !== want.tag_num)
            report_mismatch($sformatf("tag_number got %h want %h", data[7:0], want.tag_num));
        if (data[8] !== want.tag_cls)
            report_mismatch($sformatf("class got %b want %b", data[8], want.tag_cls));
        if (data[40:9] !== want.lvt)
            report_mismatch($sformatf("length_value_type got %h want %h",
                                      data[40:9], want.lvt));
        if (data[43:41] !== want.hdr_size)
            report_mismatch($sformatf("header_bytes got %0d want %0d",
                                      data[43:41], want.hdr_size));
    endtask
endclass

module tb;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_ITEMS  = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] byte_in
    logic        s_tuser;     // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;     // [7:0] tag_number, [8] class,
                              // [40:9] length_value_type, [43:41] header_bytes

    header_scoreboard sb = new();
    bit          idle_enable;
    int          stall_left = 0;
    logic [7:0]  header_q[$];

    tag_header_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Input side monitor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
    end

    // Result side monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_header(m_tdata);
    end

    // Receiver backpressure: m_tready dropped low in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Present one byte and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random byte leaning toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fill header_q with one well-formed header of random content
    function automatic void build_header();
        logic [3:0] nib;
        logic       cls;
        logic [2:0] lvt;
        header_q.delete();
        nib = ($urandom_range(0, 3) == 0) ? thd_pkg::TAG_EXT_NIBBLE
                                          : 4'($urandom_range(0, 15));
        cls = 1'($urandom_range(0, 1));
        lvt = ($urandom_range(0, 1) == 0) ? thd_pkg::LVT_EXTENDED
                                          : 3'($urandom_range(0, 7));
        header_q.push_back({nib, cls, lvt});
        if (cls && nib == thd_pkg::TAG_EXT_NIBBLE)
            header_q.push_back(pick_byte());
        if (lvt == thd_pkg::LVT_EXTENDED)
        begin
            case ($urandom_range(0, 2))
                0:
                    header_q.push_back(($urandom_range(0, 3) == 0) ? 8'd253
                                       : 8'($urandom_range(0, 253)));
                1:
                begin
                    header_q.push_back(thd_pkg::LEN_MARK_16);
                    repeat (2) header_q.push_back(pick_byte());
                end
                default:
                begin
                    header_q.push_back(thd_pkg::LEN_MARK_32);
                    repeat (4) header_q.push_back(pick_byte());
                end
            endcase
        end
    endfunction

    // Main stimulus
    initial
    begin
        int  items_sent;
        int  kind;
        int  cut;
        bit  paused;
        logic [7:0] noise;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        idle_enable = 1'b1;
        items_sent  = 0;
        paused      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte with no header open: ignored
        send_byte(8'hA5, 1'b0);
        // application tag 0, length 0
        send_byte(8'h00, 1'b1);
        // context tag with extended number 255, closing tag
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        // application tag with nibble 15, opening tag
        send_byte(8'hF6, 1'b1);
        // one-byte extended length, largest short value
        send_byte(8'h3D, 1'b1);
        send_byte(8'hFD, 1'b0);
        // extended tag number 0 and 32-bit length all ones: 7 bytes
        send_byte(8'hFD, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(thd_pkg::LEN_MARK_32, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        // 16-bit length all ones
        send_byte(8'h05, 1'b1);
        send_byte(thd_pkg::LEN_MARK_16, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // restart in the middle of a 16-bit length
        send_byte(8'h15, 1'b1);
        send_byte(thd_pkg::LEN_MARK_16, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h2F, 1'b1);
        // one-byte extended length of zero
        send_byte(8'h55, 1'b1);
        send_byte(8'h00, 1'b0);

        // Random headers, broken headers and noise
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_enable = 1'b0;
            // hold off once until the decoder has drained
            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending_headers.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 9)
            begin
                build_header();
                cut = header_q.size();
                if (kind >= 7 && cut > 1)
                    cut = $urandom_range(1, cut - 1);
                for (int i = 0; i < cut; i++)
                    send_byte(header_q[i], i == 0);
                items_sent += cut;
            end
            else
            begin
                noise = 8'($urandom_range(0, 255));
                kind  = $urandom_range(0, 1);
                send_byte(noise, kind[0]);
                if (kind[0])
                    items_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain
        while (sb.pending_headers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
